[hw/rtl/escaped_frame_deframer_unit_macros.svh]
// assertion macros used by the deframer rtl
`ifndef ESCAPED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define EFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define EFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/efd_pkg.sv]
// types and constants of the escaped frame deframer
package efd_pkg;

  localparam int unsigned STORE_DEPTH = 22;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W       = 6;

  localparam logic [7:0] TYPE_SHORT = 8'h31;
  localparam logic [7:0] TYPE_LONG  = 8'h32;
  localparam logic [7:0] TYPE_EXT   = 8'h33;

  localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(10);
  localparam logic [LEN_W-1:0] LEN_LONG  = LEN_W'(15);
  localparam logic [LEN_W-1:0] LEN_EXT   = LEN_W'(22);

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;
  localparam logic [1:0] KIND_EXT   = 2'd3;

  localparam logic [3:0] DLEN_SHORT = 4'd2;
  localparam logic [3:0] DLEN_LONG  = 4'd7;
  localparam logic [3:0] DLEN_EXT   = 4'd14;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  typedef struct packed {
    status_e      status;
    logic [1:0]   frame_type;
    logic [47:0]  timestamp;
    logic [7:0]   signal_level;
    logic [55:0]  data_first;
    logic [55:0]  data_second;
    logic [3:0]   data_length;
  } efd_result_t;

endpackage

[hw/rtl/efd_parser.sv]
// frame parser: phase, length count, byte store and frame check
module efd_parser #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic                 flush_i,
  input  logic [7:0]           escape_i,
  output logic                 res_valid_o,
  output efd_pkg::efd_result_t res_o
);
  import efd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_TYPE  = 2'd1,
    PH_FRAME = 2'd2,
    PH_ESC   = 2'd3
  } phase_e;

  phase_e                 phase_q, phase_d, cur_phase;
  logic [LEN_W-1:0]       len_q, len_d, cur_len;
  logic [7:0]             store_q [STORE_DEPTH];
  logic                   wr_en;
  logic [LEN_W-1:0]       wr_pos;
  logic [STORE_IDX_W-1:0] wr_idx;
  logic                   is_type, is_esc;
  efd_result_t            judge_res;

  assign is_type = (byte_i >= TYPE_SHORT) && (byte_i <= TYPE_EXT);
  assign is_esc  = (byte_i == escape_i);
  assign wr_idx  = wr_pos[STORE_IDX_W-1:0];

  // check of the captured frame as it stands before this byte
  always_comb begin
    judge_res = '0;
    if (store_q[0] == TYPE_SHORT && len_q == LEN_SHORT) begin
      judge_res.frame_type  = KIND_SHORT;
      judge_res.data_length = DLEN_SHORT;
      judge_res.data_first  = {store_q[8], store_q[9], 40'd0};
    end else if (store_q[0] == TYPE_LONG && len_q == LEN_LONG) begin
      judge_res.frame_type  = KIND_LONG;
      judge_res.data_length = DLEN_LONG;
      judge_res.data_first  = {store_q[8], store_q[9], store_q[10], store_q[11],
                               store_q[12], store_q[13], store_q[14]};
    end else if (store_q[0] == TYPE_EXT && len_q == LEN_EXT) begin
      judge_res.frame_type  = KIND_EXT;
      judge_res.data_length = DLEN_EXT;
      judge_res.data_first  = {store_q[8], store_q[9], store_q[10], store_q[11],
                               store_q[12], store_q[13], store_q[14]};
      judge_res.data_second = {store_q[15], store_q[16], store_q[17], store_q[18],
                               store_q[19], store_q[20], store_q[21]};
    end
    if (judge_res.frame_type == KIND_NONE) begin
      judge_res.status = ST_MISMATCH;
    end else begin
      judge_res.status       = ST_GOOD;
      judge_res.timestamp    = {store_q[1], store_q[2], store_q[3],
                                store_q[4], store_q[5], store_q[6]};
      judge_res.signal_level = store_q[7];
    end
  end

  always_comb begin
    cur_phase   = phase_q;
    cur_len     = len_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    wr_en       = 1'b0;
    wr_pos      = len_q;
    if (flush_i) begin
      phase_d = PH_HUNT;
      len_d   = '0;
    end else begin
      // oversize frame: report, then the same byte is seen while hunting
      if (len_q > LEN_W'(MAX_FRAME)) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_OVERSIZE;
        cur_phase    = PH_HUNT;
        cur_len      = '0;
      end
      phase_d = cur_phase;
      len_d   = cur_len;
      wr_pos  = cur_len;
      case (cur_phase)
        PH_HUNT: begin
          if (is_esc) begin
            phase_d = PH_TYPE;
            len_d   = '0;
          end
        end
        PH_TYPE: begin
          if (is_type) begin
            wr_en   = 1'b1;
            len_d   = cur_len + LEN_W'(1);
            phase_d = PH_FRAME;
          end else if (is_esc) begin
            len_d = '0;
          end else begin
            phase_d = PH_HUNT;
            len_d   = '0;
          end
        end
        PH_FRAME: begin
          if (is_esc) begin
            phase_d = PH_ESC;
          end else begin
            wr_en = 1'b1;
            len_d = cur_len + LEN_W'(1);
          end
        end
        PH_ESC: begin
          if (is_esc) begin
            // doubled escape is one data byte
            wr_en   = 1'b1;
            len_d   = cur_len + LEN_W'(1);
            phase_d = PH_FRAME;
          end else if (cur_len != '0) begin
            res_valid_o = 1'b1;
            res_o       = judge_res;
            if (is_type) begin
              wr_en   = 1'b1;
              wr_pos  = '0;
              len_d   = LEN_W'(1);
              phase_d = PH_FRAME;
            end else begin
              len_d   = '0;
              phase_d = PH_TYPE;
            end
          end else begin
            phase_d = PH_HUNT;
            len_d   = '0;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          len_d   = '0;
        end
      endcase
      // bytes past the store are counted only
      if (wr_pos >= LEN_W'(STORE_DEPTH)) begin
        wr_en = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      store_q[wr_idx] <= byte_i;
    end
  end

endmodule

[hw/rtl/escaped_frame_deframer_unit.sv]
// escaped frame deframer: input register, parser, result register
//
//   channel  direction  handshake                  payload
//   in       in         in_valid_i / in_stall_o    data_byte_i, flush_i
//   out      out        out_valid_o / out_stall_i  status_o .. data_length_o
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_data_i (escape value)
//
// one byte per cycle sustained while out is not stalled; a byte's result goes
// from the input register through the parser into the result register
// the parser decides a byte combinationally, one result at most per byte
// reset clears handshake state, parse phase and length; escape value is 26
// a byte that gives no result passes the parser even while out is stalled
module escaped_frame_deframer_unit #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                flush_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output efd_pkg::status_e    status_o,
  output logic [1:0]          frame_type_o,
  output logic [47:0]         timestamp_o,
  output logic [7:0]          signal_level_o,
  output logic [55:0]         data_first_o,
  output logic [55:0]         data_second_o,
  output logic [3:0]          data_length_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import efd_pkg::*;

  `include "escaped_frame_deframer_unit_macros.svh"

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_flush_q;
  logic [7:0]  escape_q;
  logic        in_acc, out_free, advance;
  logic        res_valid;
  efd_result_t res, res_q;
  logic        out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && (out_free || !res_valid);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !advance);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && res_valid;
    end
  end

  efd_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (s1_byte_q),
    .flush_i     (s1_flush_q),
    .escape_i    (escape_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      escape_q    <= 8'd26;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        escape_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= data_byte_i;
      s1_flush_q <= flush_i;
    end
    if (advance && res_valid && out_free) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign frame_type_o   = res_q.frame_type;
  assign timestamp_o    = res_q.timestamp;
  assign signal_level_o = res_q.signal_level;
  assign data_first_o   = res_q.data_first;
  assign data_second_o  = res_q.data_second;
  assign data_length_o  = res_q.data_length;

  `EFD_ASSERT_IMP(a_stall_cause, in_stall_o, s1_valid_q && out_valid_q && out_stall_i, "input stalled without a blocked result")
  `EFD_ASSERT_IMP(a_no_overwrite, advance && res_valid, out_free, "result register overwritten while held")
  `EFD_ASSERT_IMP(a_good_fields, out_valid_o && status_o == ST_GOOD, frame_type_o != KIND_NONE && data_length_o != 4'd0, "good frame without type or length")
  `EFD_ASSERT_IMP(a_bad_fields, out_valid_o && status_o != ST_GOOD, frame_type_o == KIND_NONE && data_length_o == 4'd0, "bad frame carries type or length")
  `EFD_ASSERT_NXT(a_flush_quiet, advance && s1_flush_q && !(out_valid_q && out_stall_i), !out_valid_q, "flush produced a result")

endmodule

[dv/escaped_frame_deframer_unit_tb.sv]
// self-checking testbench of the escaped frame deframer
module escaped_frame_deframer_unit_tb;

  import efd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TYPE,
    PH_BODY,
    PH_ESCAPED
  } parse_phase_e;

  // tracks the parser state, predicts decoded frames and checks them in order
  class frame_checker #(int unsigned MAX_LEN = 32);
    logic [7:0]   escape;
    parse_phase_e phase;
    logic [5:0]   fill;
    logic [7:0]   store [STORE_DEPTH];
    efd_result_t  pending_frames [$];
    int unsigned  errors;

    function new(logic [7:0] esc_reset);
      escape = esc_reset;
      phase  = PH_HUNT;
      fill   = '0;
      errors = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void set_escape(logic [7:0] v);
      escape = v;
    endfunction

    function bit is_type(logic [7:0] b);
      return b >= TYPE_SHORT && b <= TYPE_EXT;
    endfunction

    function void put(logic [7:0] b);
      if (fill < STORE_DEPTH) store[fill] = b;
      fill = fill + 6'd1;
    endfunction

    function efd_result_t decode_frame();
      efd_result_t r;
      logic [1:0]  kind;
      int unsigned dlen;
      r    = '0;
      kind = KIND_NONE;
      dlen = 0;
      if (store[0] == TYPE_SHORT && fill == LEN_SHORT) begin
        kind = KIND_SHORT;
        dlen = int'(DLEN_SHORT);
      end else if (store[0] == TYPE_LONG && fill == LEN_LONG) begin
        kind = KIND_LONG;
        dlen = int'(DLEN_LONG);
      end else if (store[0] == TYPE_EXT && fill == LEN_EXT) begin
        kind = KIND_EXT;
        dlen = int'(DLEN_EXT);
      end
      if (kind == KIND_NONE) begin
        r.status = ST_MISMATCH;
        return r;
      end
      r.status       = ST_GOOD;
      r.frame_type   = kind;
      for (int i = 1; i <= 6; i++) r.timestamp = {r.timestamp[39:0], store[i]};
      r.signal_level = store[7];
      for (int i = 0; i < 7; i++) begin
        r.data_first  = {r.data_first[47:0], (i < dlen) ? store[8 + i] : 8'h00};
        r.data_second = {r.data_second[47:0], (i + 7 < dlen) ? store[15 + i] : 8'h00};
      end
      r.data_length  = 4'(dlen);
      return r;
    endfunction

    // one accepted input transaction
    function void take_byte(logic [7:0] b, logic flush);
      efd_result_t r;
      if (flush) begin
        phase = PH_HUNT;
        fill  = '0;
        return;
      end
      if (fill > MAX_LEN) begin
        r        = '0;
        r.status = ST_OVERSIZE;
        pending_frames.push_back(r);
        phase = PH_HUNT;
        fill  = '0;
      end
      case (phase)
        PH_HUNT: begin
          if (b == escape) begin
            phase = PH_TYPE;
            fill  = '0;
          end
        end
        PH_TYPE: begin
          // type test wins over a repeated escape here
          if (is_type(b)) begin
            put(b);
            phase = PH_BODY;
          end else if (b == escape) begin
            fill = '0;
          end else begin
            phase = PH_HUNT;
            fill  = '0;
          end
        end
        PH_BODY: begin
          if (b == escape) phase = PH_ESCAPED;
          else put(b);
        end
        default: begin
          if (b == escape) begin
            put(b);
            phase = PH_BODY;
          end else if (fill != 0) begin
            pending_frames.push_back(decode_frame());
            fill = '0;
            if (is_type(b)) begin
              put(b);
              phase = PH_BODY;
            end else begin
              phase = PH_TYPE;
            end
          end else begin
            phase = PH_HUNT;
            fill  = '0;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [55:0] want, logic [55:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // one accepted output transaction
    function void check_frame(efd_result_t got);
      efd_result_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: status expected no frame, got %0h", $time, got.status);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      compare_field("status", 56'(want.status), 56'(got.status));
      compare_field("frame_type", 56'(want.frame_type), 56'(got.frame_type));
      compare_field("timestamp", 56'(want.timestamp), 56'(got.timestamp));
      compare_field("signal_level", 56'(want.signal_level), 56'(got.signal_level));
      compare_field("data_first", want.data_first, got.data_first);
      compare_field("data_second", want.data_second, got.data_second);
      compare_field("data_length", 56'(want.data_length), 56'(got.data_length));
    endfunction
  endclass

  localparam int unsigned MAX_FRAME      = 32;
  localparam logic [7:0]  ESC_AT_RESET   = 8'd26;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASE_ITEMS    = 170;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        flush_i     = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [7:0]  cfg_data_i  = 8'h00;
  logic        in_stall_o;
  logic        out_valid_o;
  status_e     status_o;
  logic [1:0]  frame_type_o;
  logic [47:0] timestamp_o;
  logic [7:0]  signal_level_o;
  logic [55:0] data_first_o;
  logic [55:0] data_second_o;
  logic [3:0]  data_length_o;
  logic        cfg_ready_o;

  frame_checker #(MAX_FRAME) board;
  bit          quiet_send;
  bit          quiet_recv;
  int unsigned bytes_sent;
  int unsigned idle_cycles;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  escaped_frame_deframer_unit #(
    .MAX_FRAME(MAX_FRAME)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .flush_i       (flush_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .frame_type_o  (frame_type_o),
    .timestamp_o   (timestamp_o),
    .signal_level_o(signal_level_o),
    .data_first_o  (data_first_o),
    .data_second_o (data_second_o),
    .data_length_o (data_length_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic flush);
    int unsigned gap;
    gap = quiet_send ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    flush_i     <= flush;
    do @(posedge clk_i); while (in_stall_o);
    board.take_byte(b, flush);
    bytes_sent++;
  endtask

  // a data byte equal to the escape goes out doubled
  task automatic send_body(input logic [7:0] b);
    send_byte(b, 1'b0);
    if (b == board.escape) send_byte(b, 1'b0);
  endtask

  function automatic logic [7:0] pick_byte();
    return ($urandom_range(0, 7) == 0) ? board.escape : 8'($urandom);
  endfunction

  // opens a frame and leaves it open; the next escape closes it
  task automatic send_frame(input logic [7:0] kind_byte, input int unsigned len);
    send_byte(board.escape, 1'b0);
    send_byte(kind_byte, 1'b0);
    repeat (len - 1) send_body(pick_byte());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_escape(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_escape(v);
  endtask

  task automatic random_traffic(input int unsigned goal);
    int unsigned pick;
    int unsigned k;
    logic [7:0]  closer;
    while (bytes_sent < goal) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 2);
      if (pick < 55) begin
        send_frame(8'(TYPE_SHORT + k),
                   int'((k == 0) ? LEN_SHORT : (k == 1) ? LEN_LONG : LEN_EXT));
      end else if (pick < 70) begin
        send_frame(8'(TYPE_SHORT + k), $urandom_range(1, 30));
      end else if (pick < 75) begin
        send_frame(8'(TYPE_SHORT + k), $urandom_range(MAX_FRAME + 1, MAX_FRAME + 8));
      end else if (pick < 85) begin
        closer = 8'($urandom);
        if (closer == board.escape) closer = closer ^ 8'h01;
        send_byte(board.escape, 1'b0);
        send_byte(closer, 1'b0);
      end else if (pick < 90) begin
        send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0);
      end
    end
  endtask

  initial begin
    logic [7:0] short_body [9];
    logic [7:0] esc_plan [6];
    board      = new(ESC_AT_RESET);
    bytes_sent = 0;
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    short_body = '{8'h00, 8'hFF, ESC_AT_RESET, 8'h80, 8'h01, 8'h7F, 8'hFF, 8'h00, 8'hA5};
    esc_plan   = '{8'h00, 8'hFF, ESC_AT_RESET, TYPE_EXT, TYPE_SHORT, 8'($urandom)};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // noise and a flush while hunting
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // repeated escape before the type, good short frame with an escaped data byte
    send_byte(ESC_AT_RESET, 1'b0);
    send_byte(ESC_AT_RESET, 1'b0);
    send_byte(TYPE_SHORT, 1'b0);
    foreach (short_body[i]) send_body(short_body[i]);
    // close on a non-type byte, then a stray byte drops back to hunting
    send_byte(ESC_AT_RESET, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h40, 1'b0);
    // partial frame abandoned by flush
    send_byte(ESC_AT_RESET, 1'b0);
    send_byte(TYPE_LONG, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h5A, 1'b1);

    foreach (esc_plan[p]) begin
      drain();
      write_escape(esc_plan[p]);
      quiet_send = (p == 2) || ($urandom_range(0, 3) == 0);
      quiet_recv = (p == 2) || ($urandom_range(0, 3) == 0);
      random_traffic(bytes_sent + PHASE_ITEMS);
    end

    drain();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver backpressure, drawn once per result
  initial begin
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = quiet_recv ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    efd_result_t got;
    if (rst_ni && out_fire) begin
      got.status       = status_o;
      got.frame_type   = frame_type_o;
      got.timestamp    = timestamp_o;
      got.signal_level = signal_level_o;
      got.data_first   = data_first_o;
      got.data_second  = data_second_o;
      got.data_length  = data_length_o;
      board.check_frame(got);
    end
  end

  // ends a run that stops moving transactions
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/efd_pkg.sv
hw/rtl/efd_parser.sv
hw/rtl/escaped_frame_deframer_unit.sv
dv/escaped_frame_deframer_unit_tb.sv
